### rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants and types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int CoefWidth = 16;  // coefficient width, Q8.8
  localparam int FracBits  = 16;  // fraction bits of the roots
  localparam int RootWidth = 32;  // root width, Q16.16

  typedef enum logic [1:0] {
    StNone  = 2'd0,
    StOne   = 2'd1,
    StTwo   = 2'd2,
    StDegen = 2'd3
  } status_e;

endpackage

### rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One bit-pair step of the integer square root, registered.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int RW   = 33,
  parameter int TagW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [RW+2:0]     rem_i,
  input  logic [RW-1:0]     root_i,
  input  logic [TagW-1:0]   tag_i,
  output logic              valid_o,
  output logic [2*RW-1:0]   rad_o,
  output logic [RW+2:0]     rem_o,
  output logic [RW-1:0]     root_o,
  output logic [TagW-1:0]   tag_o
);

  logic [RW+2:0] rem_n;
  logic [RW+2:0] trial;
  logic          fits;

  // the remainder never exceeds twice the partial root, so its top bits are clear
  assign rem_n = {rem_i[RW:0], rad_i[2*RW-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign fits  = (rem_n >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*RW-3:0], 2'b00};
      rem_o  <= fits ? (rem_n - trial) : rem_n;
      root_o <= {root_i[RW-2:0], fits};
      tag_o  <= tag_i;
    end
  end

endmodule

### rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring-division step for both root numerators, registered.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int QW   = 34,
  parameter int DW   = 17,
  parameter int TagW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [DW-1:0]   den_i,
  input  logic [QW-1:0]   num_i [2],
  input  logic [DW-1:0]   rem_i [2],
  input  logic [QW-1:0]   quo_i [2],
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [DW-1:0]   den_o,
  output logic [QW-1:0]   num_o [2],
  output logic [DW-1:0]   rem_o [2],
  output logic [QW-1:0]   quo_o [2],
  output logic [TagW-1:0] tag_o
);

  logic [DW:0] part [2];
  logic        fits [2];
  logic [DW:0] diff [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      part[l] = {rem_i[l], num_i[l][QW-1]};
      fits[l] = (part[l] >= {1'b0, den_i});
      diff[l] = part[l] - {1'b0, den_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      tag_o <= tag_i;
      for (int l = 0; l < 2; l++) begin
        num_o[l] <= {num_i[l][QW-2:0], 1'b0};
        rem_o[l] <= fits[l] ? diff[l][DW-1:0] : part[l][DW-1:0];
        quo_o[l] <= {quo_i[l][QW-2:0], fits[l]};
      end
    end
  end

endmodule

### rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c from signed Q8.8 coefficients.
// ----------------------------------------------------------------------------
// Slave stream: tdata carries coef_quad, coef_lin, coef_const (lowest first),
// each COEF_WIDTH bits, two's complement Q8.8.
// Master stream: tdata carries root_plus then root_minus, signed Q16.16;
// tuser carries root_status (0 none, 1 one, 2 two, 3 zero a) then
// root_saturated.
// The block is a pipeline: two multiply/discriminant stages, a row of
// COEF_WIDTH+17 square-root cells (one root bit each), a numerator stage,
// a row of COEF_WIDTH+18 divider cells (one quotient bit each, both roots
// side by side) and the output register. One word is taken every cycle
// while the receiver does not stall the output.
// Reset empties the pipeline. When the receiver stalls with a word waiting
// in the output register, the whole pipeline holds and tready drops; it
// moves again in the cycle the receiver takes the word.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::CoefWidth
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // coef_quad, coef_lin, coef_const
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // root_plus, root_minus
  output logic [2*qrs_pkg::RootWidth-1:0]       m_axis_tdata,
  // root_status, root_saturated
  output logic [2:0]                            m_axis_tuser
);

  import qrs_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int DMW  = 2*W + 1;           // discriminant magnitude
  localparam int RW   = W + FracBits + 1;  // square root width
  localparam int DW   = W + 1;             // 2|a|
  localparam int NW   = W + FracBits + 3;  // signed numerator
  localparam int QW   = NW - 1;            // numerator magnitude
  localparam int EW   = (QW > RootWidth + 1) ? QW : RootWidth + 1;
  localparam int STW  = W + DW + 3;        // tag through the root row
  localparam int DTW  = 4;                 // tag through the divider row

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // -------- products
  logic signed [W-1:0]   a_in, b_in, c_in;
  logic                  v1_q;
  logic signed [2*W-1:0] bsq_q, ac_q;
  logic signed [W-1:0]   a1_q, b1_q;

  assign a_in = s_axis_tdata[W-1:0];
  assign b_in = s_axis_tdata[2*W-1:W];
  assign c_in = s_axis_tdata[3*W-1:2*W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bsq_q <= b_in * b_in;
      ac_q  <= a_in * c_in;
      a1_q  <= a_in;
      b1_q  <= b_in;
    end
  end

  // -------- discriminant and class
  logic signed [2*W+2:0] disc;
  status_e               st_d;
  logic                  v2_q;
  status_e               st2_q;
  logic [DMW-1:0]        dmag2_q;
  logic signed [W-1:0]   b2_q;
  logic                  aneg2_q;
  logic [DW-1:0]         den2_q;

  assign disc = {{3{bsq_q[2*W-1]}}, bsq_q} - ({{3{ac_q[2*W-1]}}, ac_q} <<< 2);

  always_comb begin
    if (a1_q == '0) begin
      st_d = StDegen;
    end else if (disc[2*W+2]) begin
      st_d = StNone;
    end else if (disc == '0) begin
      st_d = StOne;
    end else begin
      st_d = StTwo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st2_q   <= st_d;
      // no root needed for no-root or zero-a words: feed zero
      dmag2_q <= (st_d == StTwo) ? disc[DMW-1:0] : '0;
      b2_q    <= b1_q;
      aneg2_q <= a1_q[W-1];
      den2_q  <= a1_q[W-1] ? ({1'b0, -a1_q} << 1) : ({1'b0, a1_q} << 1);
    end
  end

  // -------- square-root row
  logic            sv   [RW+1];
  logic [2*RW-1:0] srad [RW+1];
  logic [RW+2:0]   srem [RW+1];
  logic [RW-1:0]   sroot[RW+1];
  logic [STW-1:0]  stag [RW+1];

  assign sv[0]    = v2_q;
  assign srad[0]  = {1'b0, dmag2_q, {(2*FracBits){1'b0}}};
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign stag[0]  = {st2_q, aneg2_q, den2_q, b2_q};

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    qrs_sqrt_cell #(.RW(RW), .TagW(STW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[k]),
      .rad_i   (srad[k]),
      .rem_i   (srem[k]),
      .root_i  (sroot[k]),
      .tag_i   (stag[k]),
      .valid_o (sv[k+1]),
      .rad_o   (srad[k+1]),
      .rem_o   (srem[k+1]),
      .root_o  (sroot[k+1]),
      .tag_o   (stag[k+1])
    );
  end

  // -------- numerators
  logic signed [W-1:0]  b_s;
  logic [DW-1:0]        den_s;
  logic                 aneg_s;
  logic [1:0]           st_s;
  logic signed [NW-1:0] base, nump, numm;
  logic                 v3_q;
  logic [QW-1:0]        n3_q [2];
  logic [DW-1:0]        den3_q;
  logic [DTW-1:0]       tag3_q;

  assign b_s    = stag[RW][W-1:0];
  assign den_s  = stag[RW][W+DW-1:W];
  assign aneg_s = stag[RW][W+DW];
  assign st_s   = stag[RW][STW-1 -: 2];
  assign base   = -({{(NW-W){b_s[W-1]}}, b_s} <<< FracBits);
  assign nump   = base + $signed({{(NW-RW){1'b0}}, sroot[RW]});
  assign numm   = base - $signed({{(NW-RW){1'b0}}, sroot[RW]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= sv[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n3_q[0] <= nump[NW-1] ? QW'(-nump) : nump[QW-1:0];
      n3_q[1] <= numm[NW-1] ? QW'(-numm) : numm[QW-1:0];
      den3_q  <= den_s;
      // quotient signs: numerator sign against the sign of a
      tag3_q  <= {st_s, nump[NW-1] ^ aneg_s, numm[NW-1] ^ aneg_s};
    end
  end

  // -------- divider row
  logic           dv   [QW+1];
  logic [DW-1:0]  dden [QW+1];
  logic [QW-1:0]  dnum [QW+1][2];
  logic [DW-1:0]  drem [QW+1][2];
  logic [QW-1:0]  dquo [QW+1][2];
  logic [DTW-1:0] dtag [QW+1];

  assign dv[0]      = v3_q;
  assign dden[0]    = den3_q;
  assign dnum[0]    = n3_q;
  assign drem[0][0] = '0;
  assign drem[0][1] = '0;
  assign dquo[0][0] = '0;
  assign dquo[0][1] = '0;
  assign dtag[0]    = tag3_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    qrs_div_cell #(.QW(QW), .DW(DW), .TagW(DTW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[k]),
      .den_i   (dden[k]),
      .num_i   (dnum[k]),
      .rem_i   (drem[k]),
      .quo_i   (dquo[k]),
      .tag_i   (dtag[k]),
      .valid_o (dv[k+1]),
      .den_o   (dden[k+1]),
      .num_o   (dnum[k+1]),
      .rem_o   (drem[k+1]),
      .quo_o   (dquo[k+1]),
      .tag_o   (dtag[k+1])
    );
  end

  // -------- clip and output register
  status_e              st_f;
  logic [EW-1:0]        qx   [2];
  logic                 qneg [2];
  logic [RootWidth-1:0] root [2];
  logic                 clip [2];
  logic                 out_v_q;
  logic [RootWidth-1:0] plus_q, minus_q;
  status_e              st_q;
  logic                 sat_q;

  assign st_f = status_e'(dtag[QW][3:2]);

  always_comb begin
    qneg[0] = dtag[QW][1];
    qneg[1] = dtag[QW][0];
    for (int l = 0; l < 2; l++) begin
      qx[l] = EW'(dquo[QW][l]);
      if (qneg[l]) begin
        clip[l] = (qx[l] > EW'({1'b1, {(RootWidth-1){1'b0}}}));
        root[l] = clip[l] ? {1'b1, {(RootWidth-1){1'b0}}} : RootWidth'(-qx[l]);
      end else begin
        clip[l] = (qx[l] > EW'({1'b0, {(RootWidth-1){1'b1}}}));
        root[l] = clip[l] ? {1'b0, {(RootWidth-1){1'b1}}} : qx[l][RootWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_f;
      if (st_f == StOne || st_f == StTwo) begin
        plus_q  <= root[0];
        minus_q <= root[1];
        sat_q   <= clip[0] | clip[1];
      end else begin
        plus_q  <= '0;
        minus_q <= '0;
        sat_q   <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {minus_q, plus_q};
  assign m_axis_tuser  = {sat_q, st_q};

`ifndef ASSERT_OFF
  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st_q == StNone || st_q == StDegen)
      |-> (plus_q == '0 && minus_q == '0 && !sat_q))
    else $error("root fields not cleared without real roots");

  a_one_root_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st_q == StOne |-> plus_q == minus_q)
    else $error("single root differs between fields");

  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready out of step with output stall");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(sv[RW]) && $stable(dv[QW]))
    else $error("pipeline moved during a stall");
`endif

endmodule

### tb/quadratic_root_solver_tb.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// Streams coefficient words through the solver under varied handshake idling
// and checks every result word against a behavioural root predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int CW = CoefWidth;
  localparam int DataW = ((3*CW+7)/8)*8;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    status_e           status;
    logic signed [31:0] root_p;
    logic signed [31:0] root_m;
    logic              sat;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;

  logic [DataW-1:0] coef_q[$];
  roots_t roots_q[$];
  int send_idle = 0, recv_idle = 0;
  int errors = 0, n_words = 0, n_results = 0, watch = 0;
  int st_count[4];

  always #6 clk_i = ~clk_i;

  quadratic_root_solver DUT (.*);

  function automatic logic [63:0] isqrt128(logic [127:0] v);
    logic [127:0] rem, trial;
    logic [63:0] r;
    rem = '0; r = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2*k)) & 128'd3);
      trial = ({64'd0, r} << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        r = (r << 1) | 64'd1;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] clip_div(logic signed [63:0] num,
                                           logic signed [63:0] den, inout logic sat);
    logic [63:0] q;
    logic neg;
    q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
    neg = (num < 0) != (den < 0);
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 64'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return -q[31:0];
  endfunction

  function automatic roots_t solve_roots(logic [DataW-1:0] w);
    logic signed [63:0] a, b, c, s, base;
    logic signed [127:0] disc;
    logic sat;
    roots_t r;
    a = $signed(w[CW-1:0]);
    b = $signed(w[2*CW-1:CW]);
    c = $signed(w[3*CW-1:2*CW]);
    r = '0;
    sat = 1'b0;
    if (a == 0) begin
      r.status = StDegen;
      return r;
    end
    disc = 128'(b*b) - 128'(4*a*c);
    if (disc < 0) begin
      r.status = StNone;
      return r;
    end
    s = $signed(isqrt128(disc << 32));
    base = -b * 65536;
    r.root_p = clip_div(base + s, 2*a, sat);
    r.root_m = clip_div(base - s, 2*a, sat);
    r.status = (disc == 0) ? StOne : StTwo;
    r.sat = sat;
    return r;
  endfunction

  function automatic logic [DataW-1:0] pack_coefs(int a, int b, int c);
    logic [DataW-1:0] w;
    w = '0;
    w[CW-1:0] = a[CW-1:0];
    w[2*CW-1:CW] = b[CW-1:0];
    w[3*CW-1:2*CW] = c[CW-1:0];
    return w;
  endfunction

  // driver: advance to the next word only on a handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        roots_q.push_back(solve_roots(s_axis_tdata));
        n_words++;
      end
      if ((!s_axis_tvalid || s_axis_tready) && coef_q.size() > 0
          && $urandom_range(99) >= send_idle) begin
        s_axis_tdata <= coef_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else if (s_axis_tvalid && s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    roots_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (roots_q.size() == 0) begin
          $display("%0t: unexpected word tdata=%h tuser=%h", $time, m_axis_tdata,
                   m_axis_tuser);
          errors++;
        end else begin
          e = roots_q.pop_front();
          st_count[e.status]++;
          if (m_axis_tuser[1:0] != e.status || m_axis_tuser[2] != e.sat
              || m_axis_tdata[31:0] != e.root_p || m_axis_tdata[63:32] != e.root_m) begin
            $display("%0t: mismatch exp st=%0d p=%h m=%h sat=%b act st=%0d p=%h m=%h sat=%b",
                     $time, e.status, e.root_p, e.root_m, e.sat, m_axis_tuser[1:0],
                     m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[2]);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) watch = 0;
      else watch++;
      if (watch > WatchLimit) begin
        $display("%0t: watchdog timeout", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int ext[5];
    int a, b, c;
    int m, n, sg;
    ext = '{-32768, -1, 0, 1, 32767};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, zero a, double roots, negative discriminant, clipping
    foreach (ext[i]) coef_q.push_back(pack_coefs(ext[i], ext[i], ext[(i+2)%5]));
    coef_q.push_back(pack_coefs(0, 32767, -32768));
    coef_q.push_back(pack_coefs(256, 512, 256));     // (x+1)^2
    coef_q.push_back(pack_coefs(-256, 1024, -1024)); // -(x-2)^2
    coef_q.push_back(pack_coefs(256, 0, 256));       // no real roots
    coef_q.push_back(pack_coefs(256, 0, -256));      // +-1
    coef_q.push_back(pack_coefs(1, 32767, -32768));  // clipped
    coef_q.push_back(pack_coefs(-1, -32768, 32767));
    coef_q.push_back(pack_coefs(32767, -32768, -32768));
    coef_q.push_back(pack_coefs(-32768, -32768, -32768));
    coef_q.push_back(pack_coefs(1, 2, 1));
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 50 : (ph == 3) ? 13 : 0;
      recv_idle = (ph == 2) ? 50 : (ph == 3) ? 13 : 0;
      for (int i = 0; i < 450; i++) begin
        case ($urandom_range(3))
          0: begin   // double root: a = s*m^2, b = +-2*s*m*n, c = s*n^2
            m = $urandom_range(1, 40);
            n = $urandom_range(1, 100);
            sg = ($urandom_range(1) != 0) ? 1 : -1;
            a = sg * m * m;
            c = sg * n * n;
            b = 2 * m * n * (($urandom_range(1) != 0) ? 1 : -1);
          end
          1: begin
            a = $urandom_range(0, 8) - 4; b = $signed(16'($urandom));
            c = $signed(16'($urandom));
          end
          default: begin
            a = $signed(16'($urandom)); b = $signed(16'($urandom));
            c = $signed(16'($urandom));
          end
        endcase
        coef_q.push_back(pack_coefs(a, b, c));
      end
      while (coef_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    end
    while (roots_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d coefficient words, checked %0d results", n_words, n_results);
    $display("Status mix: none %0d, one %0d, two %0d, zero a %0d",
             st_count[0], st_count[1], st_count[2], st_count[3]);
    if (errors == 0 && roots_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### quadratic_root_solver.f
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
tb/quadratic_root_solver_tb.sv
